FILE: hw/rtl/radio_spi_register_fifo_top_assert.svh
// Assertion macros for the checker file.
`ifndef RADIO_SPI_REGISTER_FIFO_TOP_ASSERT_SVH
`define RADIO_SPI_REGISTER_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RSRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/rsrf_pkg.sv
// ----------------------------------------------------------------------------
// rsrf_pkg
// Types and codes shared by the SPI register file and payload FIFO block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsrf_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_ACK
  } state_t;

  // input item modes
  localparam logic [1:0] MODE_SPI    = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_PACKET = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SPI    = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // command codes
  localparam logic [7:0] CMD_REG_WRITE   = 8'h20;
  localparam logic [7:0] CMD_LIMIT       = 8'h40;
  localparam logic [7:0] CMD_W_STATUS    = 8'h27;
  localparam logic [7:0] CMD_R_RX_PAY    = 8'h61;
  localparam logic [7:0] CMD_W_TX_PAY    = 8'hA0;
  localparam logic [7:0] CMD_W_ACK_PAY   = 8'hA8;
  localparam logic [7:0] CMD_W_TX_NOACK  = 8'hB0;
  localparam logic [7:0] CMD_TX_CLEAR    = 8'hE1;
  localparam logic [7:0] CMD_RX_CLEAR    = 8'hE2;

  // register indexes
  localparam logic [4:0] RA_CONFIG       = 5'h00;
  localparam logic [4:0] RA_STAT         = 5'h07;
  localparam logic [4:0] RA_RX_ADDR0     = 5'h0A;
  localparam logic [4:0] RA_RX_ADDR1     = 5'h0B;
  localparam logic [4:0] RA_TX_ADDR      = 5'h10;
  localparam logic [4:0] RA_RX_WIDTH0    = 5'h11;
  localparam logic [4:0] RA_FIFO_STAT    = 5'h17;

  localparam logic [7:0] IRQ_BITS   = 8'h70;
  localparam logic [7:0] REPLY_NONE = 8'hFF;
  localparam logic [7:0] POS_IDLE   = 8'hFF;
  localparam logic [7:0] POS_MAX    = 8'hFE;
  localparam logic [7:0] ADDR_HI_A  = 8'hE7;
  localparam logic [7:0] ADDR_HI_B  = 8'hC2;

  localparam logic [7:0] REG_INIT [32] = '{
    8'h08, 8'h3F, 8'h03, 8'h03, 8'h03, 8'h02, 8'h0E, 8'h0E,
    8'h00, 8'h00, 8'hE7, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6,
    8'hE7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h11,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

FILE: hw/rtl/radio_spi_register_fifo_top.sv
// ----------------------------------------------------------------------------
// radio_spi_register_fifo_top
// SPI slave register file with RX and TX payload FIFOs and packet ack logic.
// ----------------------------------------------------------------------------
//  channel   signals                                     transfer
//  input     start/busy, mode data chip_select
//            chip_enable has_byte last                   start & !busy
//  result    done, kind data_res last_res overrun
//            irq_rise                                    done (one cycle)
//
//  An item is taken when start & !busy; its result, if any, shows the cycle
//  after. A packet end that carries an ack payload gives the ack bytes
//  instead and holds busy while the TX payload RAM streams payload length
//  bytes, one byte a cycle; the bytes come out the cycle after the RAM reads.
//  Reset is synchronous; no clearing pass is needed. Results cannot stall.
`timescale 1ns / 1ps

module radio_spi_register_fifo_top
  import rsrf_pkg::*;
#(
  parameter int FIFO_DEPTH    = 3,
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [7:0] data,
  input  logic       chip_select,
  input  logic       chip_enable,
  input  logic       has_byte,
  input  logic       last,
  output logic       done,
  output logic [1:0] kind,
  output logic [7:0] data_res,
  output logic       last_res,
  output logic       overrun,
  output logic       irq_rise
);

  localparam int SLOT_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int OFF_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int OCC_W     = $clog2(FIFO_DEPTH + 1);
  localparam int LEN_W     = $clog2(PAYLOAD_BYTES + 1);
  localparam int IL_W      = $clog2(PAYLOAD_BYTES + 2);
  localparam int RAM_DEPTH = FIFO_DEPTH * PAYLOAD_BYTES;
  localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(FIFO_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_BYTES);
  localparam logic [IL_W-1:0]  IL_MAX   = IL_W'(PAYLOAD_BYTES);

  state_t state, state_next;

  logic [7:0]        regs       [32];
  logic [7:0]        regs_next  [32];
  logic [7:0]        ahb        [12];
  logic [7:0]        ahb_next   [12];
  logic [LEN_W-1:0]  rx_len     [FIFO_DEPTH];
  logic [LEN_W-1:0]  rx_len_next[FIFO_DEPTH];
  logic [LEN_W-1:0]  tx_len     [FIFO_DEPTH];
  logic [LEN_W-1:0]  tx_len_next[FIFO_DEPTH];
  logic [OCC_W-1:0]  rx_occ, rx_occ_next, tx_occ, tx_occ_next;
  logic [SLOT_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [SLOT_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic              sel, sel_next, en, en_next;
  logic [7:0]        cmd, cmd_next, bp, bp_next;
  logic [OFF_W-1:0]  paypos, paypos_next;
  logic [2:0]        irq_last, irq_last_next;
  logic [IL_W-1:0]   il, il_next;

  logic              res_valid, res_valid_next;
  logic [1:0]        res_kind, res_kind_next;
  logic [7:0]        res_data, res_data_next;
  logic              res_last, res_last_next;
  logic              res_ovr, res_ovr_next;
  logic              res_irq, res_irq_next;
  logic              res_rx, res_rx_next;

  logic [SLOT_W-1:0] ack_slot, ack_slot_next;
  logic [LEN_W-1:0]  ack_n, ack_n_next, ack_i, ack_i_next;
  logic              ack_pend, ack_pend_next, ack_pend_last, ack_pend_last_next;
  logic              ack_done;
  logic              go_ack;

  logic              accept;
  logic              rx_we, tx_we;
  logic [AW-1:0]     rx_waddr, tx_waddr, rx_raddr, tx_raddr;
  logic [7:0]        rx_wdata, tx_wdata, rx_q, tx_q;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  function automatic logic [AW-1:0] ram_addr(input logic [SLOT_W-1:0] s,
                                             input logic [OFF_W-1:0] o);
    return AW'(s) * AW'(PAYLOAD_BYTES) + AW'(o);
  endfunction

  function automatic logic [7:0] fifo_stat(input logic [OCC_W-1:0] ro,
                                           input logic [OCC_W-1:0] to);
    return ((ro == '0) ? 8'h01 : 8'h00) | ((ro >= OCC_FULL) ? 8'h02 : 8'h00) |
           ((to == '0) ? 8'h10 : 8'h00) | ((to >= OCC_FULL) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] status_stat(input logic [7:0] st,
                                             input logic [OCC_W-1:0] ro,
                                             input logic [OCC_W-1:0] to);
    return (st & IRQ_BITS) | ((to >= OCC_FULL) ? 8'h01 : 8'h00) |
           ((ro == '0) ? 8'h0E : 8'h00);
  endfunction

  assign accept   = start && !busy;
  assign ack_done = (ack_i == LEN_W'(ack_n - LEN_W'(1)));
  assign rx_raddr = ram_addr(rx_tail, paypos);
  assign tx_raddr = ram_addr(ack_slot, ack_i[OFF_W-1:0]);

  rsrf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .raddr (rx_raddr),
    .rdata (rx_q)
  );

  rsrf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_raddr),
    .rdata (tx_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && go_ack) begin
          state_next = ST_ACK;
        end
      end
      ST_ACK: begin
        if (ack_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_ACK:  busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // item processing: read, modify and write back the block state
  always_comb begin : proc
    logic [4:0]       rsel;
    logic [2:0]       ci;
    logic             use_ahb;
    logic [3:0]       ahb_idx;
    logic [7:0]       reg_byte;
    logic [IL_W-1:0]  len;
    logic [2:0]       irq_now;
    logic             is_tx_cmd;

    regs_next     = regs;
    ahb_next      = ahb;
    rx_len_next   = rx_len;
    tx_len_next   = tx_len;
    rx_occ_next   = rx_occ;
    tx_occ_next   = tx_occ;
    rx_head_next  = rx_head;
    rx_tail_next  = rx_tail;
    tx_head_next  = tx_head;
    tx_tail_next  = tx_tail;
    sel_next      = sel;
    en_next       = en;
    cmd_next      = cmd;
    bp_next       = bp;
    paypos_next   = paypos;
    irq_last_next = irq_last;
    il_next       = il;

    res_valid_next = 1'b0;
    res_kind_next  = KIND_STATUS;
    res_data_next  = regs[RA_STAT];
    res_last_next  = 1'b1;
    res_ovr_next   = 1'b0;
    res_irq_next   = 1'b0;
    res_rx_next    = 1'b0;

    ack_slot_next      = ack_slot;
    ack_n_next         = ack_n;
    ack_i_next         = ack_i;
    ack_pend_next      = 1'b0;
    ack_pend_last_next = 1'b0;
    go_ack             = 1'b0;

    rx_we    = 1'b0;
    rx_waddr = ram_addr(rx_head, il[OFF_W-1:0]);
    rx_wdata = data;
    tx_we    = 1'b0;
    tx_waddr = ram_addr(tx_head, paypos);
    tx_wdata = data;

    // register byte addressed by the current command and byte position
    rsel    = cmd[4:0];
    ci      = (bp > 8'd4) ? 3'd4 : bp[2:0];
    use_ahb = 1'b0;
    ahb_idx = 4'd0;
    if (ci != 3'd0) begin
      if (rsel == RA_TX_ADDR) begin
        use_ahb = 1'b1;
        ahb_idx = 4'(ci) - 4'd1;
      end else if (rsel == RA_RX_ADDR0) begin
        use_ahb = 1'b1;
        ahb_idx = 4'(ci) + 4'd3;
      end else if (rsel == RA_RX_ADDR1) begin
        use_ahb = 1'b1;
        ahb_idx = 4'(ci) + 4'd7;
      end
    end
    reg_byte  = use_ahb ? ahb[ahb_idx] : regs[rsel];
    is_tx_cmd = (cmd == CMD_W_TX_PAY) || (cmd == CMD_W_ACK_PAY) ||
                (cmd == CMD_W_TX_NOACK);
    len       = '0;
    irq_now   = regs[RA_CONFIG][6:4] & regs[RA_STAT][6:4];

    if (state == ST_ACK) begin
      ack_i_next         = ack_i + LEN_W'(1);
      ack_pend_next      = 1'b1;
      ack_pend_last_next = ack_done;
    end

    if (accept) begin
      res_valid_next = 1'b1;
      unique case (mode)
        MODE_SPI: begin
          res_kind_next = KIND_SPI;
          res_data_next = REPLY_NONE;
          if (sel) begin
            if (bp == POS_IDLE) begin
              cmd_next    = data;
              bp_next     = 8'd0;
              paypos_next = '0;
              if (data == CMD_TX_CLEAR) begin
                tx_occ_next = '0;
              end
              if (data == CMD_RX_CLEAR) begin
                rx_occ_next = '0;
              end
              if (data == CMD_TX_CLEAR || data == CMD_RX_CLEAR) begin
                regs_next[RA_FIFO_STAT] = fifo_stat(rx_occ_next, tx_occ_next);
                regs_next[RA_STAT] = status_stat(regs[RA_STAT], rx_occ_next,
                                                 tx_occ_next);
                regs_next[RA_RX_WIDTH0] = 8'(rx_len[rx_tail]);
              end
              res_data_next = regs_next[RA_STAT];
            end else begin
              if (bp < POS_MAX) begin
                bp_next     = bp + 8'd1;
                paypos_next = (paypos == OFF_W'(PAYLOAD_BYTES - 1)) ? '0 :
                              paypos + OFF_W'(1);
              end
              if (cmd == CMD_R_RX_PAY) begin
                res_rx_next = 1'b1;
              end else if (is_tx_cmd) begin
                tx_we = (tx_occ < OCC_FULL);
              end else if (cmd == CMD_W_STATUS) begin
                // write 1 to clear interrupt bits
                regs_next[RA_STAT] = regs[RA_STAT] & ~(data & IRQ_BITS);
              end else if (cmd < CMD_REG_WRITE) begin
                res_data_next = reg_byte;
              end else if (cmd < CMD_LIMIT) begin
                if (use_ahb) begin
                  ahb_next[ahb_idx] = data;
                end else begin
                  regs_next[rsel] = data;
                end
              end
            end
          end
        end
        MODE_SELECT: begin
          if (chip_select && !sel) begin
            bp_next = POS_IDLE;
          end
          if (!chip_select && sel && bp != POS_IDLE) begin
            // end of command: queue TX payload or pop RX payload
            if (is_tx_cmd) begin
              if (tx_occ < OCC_FULL) begin
                tx_len_next[tx_head] = (bp > 8'(PAYLOAD_BYTES)) ? LEN_MAX : LEN_W'(bp);
                tx_occ_next          = tx_occ + OCC_W'(1);
                tx_head_next         = next_slot(tx_head);
              end else begin
                res_ovr_next = 1'b1;
              end
            end else if (cmd == CMD_R_RX_PAY) begin
              if (rx_occ != '0) begin
                rx_occ_next  = rx_occ - OCC_W'(1);
                rx_tail_next = next_slot(rx_tail);
              end else begin
                res_ovr_next = 1'b1;
              end
            end
          end
          sel_next = chip_select;
          en_next  = chip_enable;
        end
        MODE_PACKET: begin
          len = il;
          if (has_byte) begin
            rx_we = (il < IL_MAX) && (rx_occ < OCC_FULL);
            if (il <= IL_MAX) begin
              len = il + IL_W'(1);
            end
          end
          il_next = len;
          if (!last) begin
            res_valid_next = 1'b0;
          end else begin
            il_next = '0;
            if (!en || len > IL_MAX) begin
              res_data_next = regs[RA_STAT];
            end else if (rx_occ >= OCC_FULL) begin
              regs_next[RA_FIFO_STAT] = fifo_stat(rx_occ, tx_occ);
              regs_next[RA_STAT] = status_stat(regs[RA_STAT], rx_occ, tx_occ);
              regs_next[RA_RX_WIDTH0] = 8'(rx_len[rx_tail]);
              res_data_next = regs_next[RA_STAT];
              res_ovr_next  = 1'b1;
            end else begin
              rx_len_next[rx_head] = LEN_W'(len);
              rx_head_next = next_slot(rx_head);
              rx_occ_next  = rx_occ + OCC_W'(1);
              regs_next[RA_STAT] = regs[RA_STAT] | 8'h40;
              if (tx_occ != '0) begin
                tx_tail_next = next_slot(tx_tail);
                tx_occ_next  = tx_occ - OCC_W'(1);
                regs_next[RA_STAT] = regs_next[RA_STAT] | 8'h20;
                if (tx_len[tx_tail] != '0) begin
                  go_ack         = 1'b1;
                  res_valid_next = 1'b0;
                  ack_slot_next  = tx_tail;
                  ack_n_next     = tx_len[tx_tail];
                  ack_i_next     = '0;
                end
              end
              regs_next[RA_FIFO_STAT] = fifo_stat(rx_occ_next, tx_occ_next);
              regs_next[RA_STAT] = status_stat(regs_next[RA_STAT], rx_occ_next,
                                               tx_occ_next);
              regs_next[RA_RX_WIDTH0] = 8'(rx_len_next[rx_tail]);
              res_kind_next = KIND_EMPTY;
              res_data_next = regs_next[RA_STAT];
            end
          end
        end
        MODE_TICK: begin
          irq_last_next = irq_now;
          res_irq_next  = (irq_now != 3'd0) && (irq_last == 3'd0);
        end
        default: res_valid_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 32; i++) begin
        regs[i] <= REG_INIT[i];
      end
      for (int i = 0; i < 12; i++) begin
        ahb[i] <= (i < 8) ? ADDR_HI_A : ADDR_HI_B;
      end
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        rx_len[i] <= '0;
        tx_len[i] <= '0;
      end
      rx_occ        <= '0;
      tx_occ        <= '0;
      rx_head       <= '0;
      rx_tail       <= '0;
      tx_head       <= '0;
      tx_tail       <= '0;
      sel           <= 1'b0;
      en            <= 1'b0;
      cmd           <= 8'd0;
      bp            <= 8'd0;
      paypos        <= '0;
      irq_last      <= 3'd0;
      il            <= '0;
      res_valid     <= 1'b0;
      ack_pend      <= 1'b0;
      ack_pend_last <= 1'b0;
      ack_slot      <= '0;
      ack_n         <= '0;
      ack_i         <= '0;
    end else begin
      state         <= state_next;
      regs          <= regs_next;
      ahb           <= ahb_next;
      rx_len        <= rx_len_next;
      tx_len        <= tx_len_next;
      rx_occ        <= rx_occ_next;
      tx_occ        <= tx_occ_next;
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
      sel           <= sel_next;
      en            <= en_next;
      cmd           <= cmd_next;
      bp            <= bp_next;
      paypos        <= paypos_next;
      irq_last      <= irq_last_next;
      il            <= il_next;
      res_valid     <= res_valid_next;
      ack_pend      <= ack_pend_next;
      ack_pend_last <= ack_pend_last_next;
      ack_slot      <= ack_slot_next;
      ack_n         <= ack_n_next;
      ack_i         <= ack_i_next;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    res_kind <= res_kind_next;
    res_data <= res_data_next;
    res_last <= res_last_next;
    res_ovr  <= res_ovr_next;
    res_irq  <= res_irq_next;
    res_rx   <= res_rx_next;
  end

  assign done     = res_valid | ack_pend;
  assign kind     = ack_pend ? KIND_ACK : res_kind;
  assign data_res = ack_pend ? tx_q : (res_rx ? rx_q : res_data);
  assign last_res = ack_pend ? ack_pend_last : res_last;
  assign overrun  = ack_pend ? 1'b0 : res_ovr;
  assign irq_rise = ack_pend ? 1'b0 : res_irq;

endmodule

FILE: hw/rtl/rsrf_ram.sv
// ----------------------------------------------------------------------------
// rsrf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rsrf_checker.sv
// ----------------------------------------------------------------------------
// rsrf_checker
// Port-level checks on result timing for the radio SPI register FIFO block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_spi_register_fifo_top_assert.svh"

module rsrf_checker
  import rsrf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode,
  input logic       done,
  input logic [1:0] kind,
  input logic       last_res,
  input logic       irq_rise
);

  `RSRF_ASSERT_NEXT(a_spi_reply, start && !busy && mode == MODE_SPI,
    done && kind == KIND_SPI && last_res, "SPI byte without a single reply")
  `RSRF_ASSERT_NEXT(a_status_reply,
    start && !busy && (mode == MODE_SELECT || mode == MODE_TICK),
    done && kind == KIND_STATUS && last_res, "select or tick without status reply")
  `RSRF_ASSERT_SAME(a_single_last, done && kind != KIND_ACK, last_res,
    "non-ack result not final")
  `RSRF_ASSERT_SAME(a_irq_on_status, irq_rise, done && kind == KIND_STATUS,
    "irq edge outside a status result")

endmodule

bind radio_spi_register_fifo_top rsrf_checker u_rsrf_checker (.*);
